>>> design/wpss_pkg.sv
// ----------------------------------------------------------------------------
// wpss_pkg
// Shared constants, command codes and beat types of the windowed PI steering
// and speed unit.
// ----------------------------------------------------------------------------
package wpss_pkg;

    localparam int WINDOW     = 20;
    localparam int ANGLE_BITS = 16;
    localparam int GAIN_BITS  = 16;
    localparam int CMD_BITS   = 2;
    localparam int SPEED_BITS = 16;
    localparam int FRAC_BITS  = 12;

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = ANGLE_BITS + IDX_W;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV    = 2'd2;

    localparam logic [GAIN_BITS-1:0] PROP_RESET     = 16'd3277;
    localparam logic [GAIN_BITS-1:0] INTEGRAL_RESET = 16'd3686;
    localparam logic [GAIN_BITS-1:0] DERIV_RESET    = 16'd0;

    localparam logic [CMD_BITS-1:0] CMD_GO       = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_REVERSE  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CAUTIOUS = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_STOP     = 2'd3;

    localparam int PDW_W = GAIN_BITS + 1 + IDX_W;
    localparam int PP_W  = PDW_W + 1 + ANGLE_BITS;
    localparam int PI_W  = GAIN_BITS + 1 + SUM_W;
    localparam int NUM_W = ANGLE_BITS + GAIN_BITS + IDX_W + 2;
    localparam int X_W   = NUM_W - FRAC_BITS;

    localparam logic [NUM_W-1:0] ROUND_BIAS = NUM_W'(WINDOW * (2 ** (FRAC_BITS - 1)));

    localparam int RCP_SHIFT = X_W + IDX_W;
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << RCP_SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW);
    localparam logic [X_W:0] RCP = RCP_FULL[X_W:0];
    localparam int Q_W    = 2 * X_W + 1 - RCP_SHIFT;
    localparam int TURN_W = Q_W + 1;

    localparam int CAP_W = 14;
    localparam logic [CAP_W-1:0] TURN_CAP = 14'd9216;
    localparam int MAG_W = (ANGLE_BITS > CAP_W) ? ANGLE_BITS : CAP_W;

    localparam int SPD_NUM_W = 23;
    localparam logic [SPD_NUM_W-1:0] SPD_NUM  = 23'd7446753;
    localparam logic [SPD_NUM_W-1:0] SPD_STEP = 23'd800;
    localparam int SPD_RCP_W     = 24;
    localparam int SPD_RCP_SHIFT = 32;
    localparam logic [63:0] SPD_RCP_FULL = ((64'd1 << SPD_RCP_SHIFT) + 64'd449) / 64'd450;
    localparam logic [SPD_RCP_W-1:0] SPD_RCP = SPD_RCP_FULL[SPD_RCP_W-1:0];
    localparam int SPD_PROD_W = SPD_NUM_W + SPD_RCP_W;
    localparam int SPD_GO_W   = SPD_PROD_W - SPD_RCP_SHIFT;

    localparam logic signed [SPEED_BITS-1:0] SPEED_REVERSE  = -16'sd8192;
    localparam logic signed [SPEED_BITS-1:0] SPEED_CAUTIOUS = 16'sd1638;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] err;
        logic        [CMD_BITS-1:0]   cmd;
        logic signed [SUM_W-1:0]      sum;
    } wpss_win_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] steer;
        logic        [CMD_BITS-1:0]   cmd;
    } wpss_turn_t;

endpackage

>>> design/wpss_window.sv
// ----------------------------------------------------------------------------
// wpss_window
// Error ring in a synchronous memory with its head, fill count and running
// sum; the oldest entry is read and replaced in the same access.
// ----------------------------------------------------------------------------
module wpss_window (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [wpss_pkg::ANGLE_BITS-1:0] heading,
    input  logic [wpss_pkg::CMD_BITS-1:0]        drive_cmd,
    output logic                                 win_valid,
    input  logic                                 win_ready,
    output wpss_pkg::wpss_win_t                  win_data
);
    import wpss_pkg::*;

    logic signed [ANGLE_BITS-1:0] mem [WINDOW];
    logic signed [ANGLE_BITS-1:0] rd_data_reg;

    logic [IDX_W-1:0]       head_reg, head_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [CMD_BITS-1:0]    prev_cmd_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;

    logic                         s1_valid_reg;
    logic signed [ANGLE_BITS-1:0] s1_err_reg;
    logic [CMD_BITS-1:0]          s1_cmd_reg;
    logic                         s1_full_reg;
    logic                         s1_clear_reg;
    logic                         s2_valid_reg;
    wpss_win_t                    s2_data_reg;

    logic                    accept, s1_ready, s2_ready;
    logic                    clear, full;
    logic [IDX_W-1:0]        head_eff, head_inc, wr_addr;
    logic [FILL_W-1:0]       fill_eff;
    logic [FILL_W:0]         addr_sum;
    logic signed [SUM_W-1:0] sum_base, sum_old;

    assign s2_ready  = !s2_valid_reg || win_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign accept    = in_valid && s1_ready;
    assign win_valid = s2_valid_reg;
    assign win_data  = s2_data_reg;

    always_comb
    begin
        clear    = (drive_cmd != prev_cmd_reg);
        head_eff = clear ? '0 : head_reg;
        fill_eff = clear ? '0 : fill_reg;
        full     = (fill_eff >= FILL_W'(WINDOW));
        addr_sum = (FILL_W + 1)'(head_eff) + (FILL_W + 1)'(fill_eff);
        head_inc = (head_eff == IDX_W'(WINDOW - 1)) ? '0 : head_eff + 1'b1;
        if (full)
        begin
            wr_addr = head_eff;
        end
        else if (addr_sum >= (FILL_W + 1)'(WINDOW))
        begin
            wr_addr = IDX_W'(addr_sum - (FILL_W + 1)'(WINDOW));
        end
        else
        begin
            wr_addr = addr_sum[IDX_W-1:0];
        end
        head_next = full ? head_inc : head_eff;
        fill_next = full ? fill_eff : fill_eff + 1'b1;
    end

    always_comb
    begin
        sum_base = s1_clear_reg ? '0 : sum_reg;
        sum_old  = s1_full_reg ? SUM_W'(rd_data_reg) : '0;
        sum_next = sum_base + SUM_W'(s1_err_reg) - sum_old;
    end

    // Read-first: when the window is full the oldest entry is read and
    // overwritten at the same edge.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[wr_addr] <= heading;
            rd_data_reg  <= mem[head_eff];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            fill_reg     <= '0;
            prev_cmd_reg <= CMD_GO;
            sum_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                head_reg     <= head_next;
                fill_reg     <= fill_next;
                prev_cmd_reg <= drive_cmd;
            end
            if (s1_valid_reg && s2_ready)
            begin
                sum_reg <= sum_next;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_err_reg   <= heading;
            s1_cmd_reg   <= drive_cmd;
            s1_full_reg  <= full;
            s1_clear_reg <= clear;
        end
        if (s2_ready)
        begin
            s2_data_reg.err <= s1_err_reg;
            s2_data_reg.cmd <= s1_cmd_reg;
            s2_data_reg.sum <= sum_next;
        end
    end

endmodule

>>> design/wpss_gain.sv
// ----------------------------------------------------------------------------
// wpss_gain
// Gain registers and the turn datapath: both products, rounding, division by
// the window length through a reciprocal, and saturation.
// ----------------------------------------------------------------------------
module wpss_gain (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [wpss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wpss_pkg::GAIN_BITS-1:0]      cfg_data,
    input  logic                                win_valid,
    output logic                                win_ready,
    input  wpss_pkg::wpss_win_t                 win_data,
    output logic                                turn_valid,
    input  logic                                turn_ready,
    output wpss_pkg::wpss_turn_t                turn_data
);
    import wpss_pkg::*;

    localparam logic [PDW_W-1:0] WIN_MUL = PDW_W'(WINDOW);
    localparam logic [PDW_W-1:0] PDW_RESET =
        (PDW_W'(PROP_RESET) + PDW_W'(DERIV_RESET)) * WIN_MUL;
    localparam logic signed [TURN_W-1:0] T_MAX =
        {{(TURN_W - ANGLE_BITS + 1){1'b0}}, {(ANGLE_BITS - 1){1'b1}}};
    localparam logic signed [TURN_W-1:0] T_MIN =
        {{(TURN_W - ANGLE_BITS + 1){1'b1}}, {(ANGLE_BITS - 1){1'b0}}};

    logic [GAIN_BITS-1:0] prop_gain_reg, integral_gain_reg, deriv_gain_reg;
    logic [PDW_W-1:0]     pdw_reg, pdw_next;

    logic s3_valid_reg, s4_valid_reg, s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic s3_ready, s4_ready, s5_ready, s6_ready, s7_ready;

    logic signed [PP_W-1:0]  s3_prod_p_reg;
    logic signed [PI_W-1:0]  s3_prod_i_reg;
    logic [CMD_BITS-1:0]     s3_cmd_reg, s4_cmd_reg, s5_cmd_reg, s6_cmd_reg;
    logic signed [X_W-1:0]   s4_x_reg;
    logic [X_W-1:0]          s5_mag_reg;
    logic                    s5_neg_reg, s6_neg_reg;
    logic [Q_W-1:0]          s6_q_reg;
    wpss_turn_t              s7_data_reg;

    logic signed [NUM_W-1:0]  num;
    logic [2*X_W:0]           rcp_prod;
    logic signed [TURN_W-1:0] turn_full;
    logic signed [ANGLE_BITS-1:0] turn_sat;

    assign s7_ready   = !s7_valid_reg || turn_ready;
    assign s6_ready   = !s6_valid_reg || s7_ready;
    assign s5_ready   = !s5_valid_reg || s6_ready;
    assign s4_ready   = !s4_valid_reg || s5_ready;
    assign s3_ready   = !s3_valid_reg || s4_ready;
    assign win_ready  = s3_ready;
    assign turn_valid = s7_valid_reg;
    assign turn_data  = s7_data_reg;

    assign pdw_next = (PDW_W'(prop_gain_reg) + PDW_W'(deriv_gain_reg)) * WIN_MUL;

    always_comb
    begin
        num      = NUM_W'(s3_prod_p_reg) + NUM_W'(s3_prod_i_reg) + $signed(ROUND_BIAS);
        rcp_prod = (2 * X_W + 1)'(s5_mag_reg) * (2 * X_W + 1)'(RCP);
        turn_full = s6_neg_reg ? -$signed({1'b0, s6_q_reg}) : $signed({1'b0, s6_q_reg});
        if (turn_full > T_MAX)
        begin
            turn_sat = {1'b0, {(ANGLE_BITS - 1){1'b1}}};
        end
        else if (turn_full < T_MIN)
        begin
            turn_sat = {1'b1, {(ANGLE_BITS - 1){1'b0}}};
        end
        else
        begin
            turn_sat = turn_full[ANGLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= PROP_RESET;
            integral_gain_reg <= INTEGRAL_RESET;
            deriv_gain_reg    <= DERIV_RESET;
            pdw_reg           <= PDW_RESET;
            s3_valid_reg      <= 1'b0;
            s4_valid_reg      <= 1'b0;
            s5_valid_reg      <= 1'b0;
            s6_valid_reg      <= 1'b0;
            s7_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PROP:     prop_gain_reg     <= cfg_data;
                    CFG_INTEGRAL: integral_gain_reg <= cfg_data;
                    CFG_DERIV:    deriv_gain_reg    <= cfg_data;
                    default:      ;
                endcase
            end
            pdw_reg <= pdw_next;
            if (s3_ready)
            begin
                s3_valid_reg <= win_valid;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_ready)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (s6_ready)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
            if (s7_ready)
            begin
                s7_valid_reg <= s6_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_prod_p_reg <= $signed({1'b0, pdw_reg}) * $signed(win_data.err);
            s3_prod_i_reg <= $signed({1'b0, integral_gain_reg}) * $signed(win_data.sum);
            s3_cmd_reg    <= win_data.cmd;
        end
        if (s4_ready)
        begin
            s4_x_reg   <= num[NUM_W-1:FRAC_BITS];
            s4_cmd_reg <= s3_cmd_reg;
        end
        if (s5_ready)
        begin
            s5_neg_reg <= s4_x_reg[X_W-1];
            s5_mag_reg <= s4_x_reg[X_W-1] ? (~s4_x_reg + X_W'(WINDOW)) : s4_x_reg;
            s5_cmd_reg <= s4_cmd_reg;
        end
        if (s6_ready)
        begin
            s6_q_reg   <= rcp_prod[2*X_W:RCP_SHIFT];
            s6_neg_reg <= s5_neg_reg;
            s6_cmd_reg <= s5_cmd_reg;
        end
        if (s7_ready)
        begin
            s7_data_reg.steer <= turn_sat;
            s7_data_reg.cmd   <= s6_cmd_reg;
        end
    end

endmodule

>>> design/wpss_speed.sv
// ----------------------------------------------------------------------------
// wpss_speed
// Drive speed from the command and the saturated turn, and the output
// register of the unit.
// ----------------------------------------------------------------------------
module wpss_speed (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  turn_valid,
    output logic                                  turn_ready,
    input  wpss_pkg::wpss_turn_t                  turn_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [wpss_pkg::ANGLE_BITS-1:0] steer,
    output logic signed [wpss_pkg::SPEED_BITS-1:0] drive_speed
);
    import wpss_pkg::*;

    logic s8_valid_reg, s9_valid_reg, s10_valid_reg;
    logic s8_ready, s9_ready, s10_ready;

    wpss_turn_t                   s8_data_reg, s9_data_reg;
    logic [SPD_NUM_W-1:0]         s8_num_reg;
    logic [SPD_GO_W-1:0]          s9_go_reg;
    logic signed [ANGLE_BITS-1:0] steer_reg;
    logic signed [SPEED_BITS-1:0] speed_reg, speed_next;

    logic [MAG_W-1:0]      mag_ext;
    logic [CAP_W-1:0]      mag_cap;
    logic [SPD_PROD_W-1:0] go_prod;

    assign s10_ready   = !s10_valid_reg || out_ready;
    assign s9_ready    = !s9_valid_reg || s10_ready;
    assign s8_ready    = !s8_valid_reg || s9_ready;
    assign turn_ready  = s8_ready;
    assign out_valid   = s10_valid_reg;
    assign steer       = steer_reg;
    assign drive_speed = speed_reg;

    always_comb
    begin
        mag_ext = MAG_W'($signed(turn_data.steer));
        if (turn_data.steer[ANGLE_BITS-1])
        begin
            mag_ext = -mag_ext;
        end
        mag_cap = (mag_ext > MAG_W'(TURN_CAP)) ? TURN_CAP : mag_ext[CAP_W-1:0];
        go_prod = SPD_PROD_W'(s8_num_reg) * SPD_PROD_W'(SPD_RCP);
        case (s9_data_reg.cmd)
            CMD_GO:       speed_next = SPEED_BITS'(s9_go_reg);
            CMD_REVERSE:  speed_next = SPEED_REVERSE;
            CMD_CAUTIOUS: speed_next = SPEED_CAUTIOUS;
            default:      speed_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
        end
        else
        begin
            if (s8_ready)
            begin
                s8_valid_reg <= turn_valid;
            end
            if (s9_ready)
            begin
                s9_valid_reg <= s8_valid_reg;
            end
            if (s10_ready)
            begin
                s10_valid_reg <= s9_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s8_ready)
        begin
            s8_data_reg <= turn_data;
            s8_num_reg  <= SPD_NUM - SPD_STEP * SPD_NUM_W'(mag_cap);
        end
        if (s9_ready)
        begin
            s9_data_reg <= s8_data_reg;
            s9_go_reg   <= go_prod[SPD_PROD_W-1:SPD_RCP_SHIFT];
        end
        if (s10_ready)
        begin
            steer_reg <= (s9_data_reg.cmd == CMD_STOP) ? '0 : s9_data_reg.steer;
            speed_reg <= speed_next;
        end
    end

endmodule

>>> design/windowed_pi_steering_speed_unit.sv
// ----------------------------------------------------------------------------
// windowed_pi_steering_speed_unit
// Each accepted beat passes through the registered stages s1 to s10.
// Throughput: one beat per cycle while out_ready allows; the error ring
// memory is read and written once per beat and its running sum is updated
// in the stage after the read. Reset clears the ring head, fill count, sum,
// previous command and all valid flags and loads the reset gains; the ring
// memory is not cleared, as the fill count keeps unwritten entries out of the sum.
// ----------------------------------------------------------------------------
module windowed_pi_steering_speed_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [wpss_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wpss_pkg::GAIN_BITS-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [wpss_pkg::ANGLE_BITS-1:0] heading,
    input  logic [wpss_pkg::CMD_BITS-1:0]         drive_cmd,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [wpss_pkg::ANGLE_BITS-1:0] steer,
    output logic signed [wpss_pkg::SPEED_BITS-1:0] drive_speed
);
    import wpss_pkg::*;

    logic       win_valid, win_ready;
    wpss_win_t  win_data;
    logic       turn_valid, turn_ready;
    wpss_turn_t turn_data;

    wpss_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .heading   (heading),
        .drive_cmd (drive_cmd),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .win_data  (win_data)
    );

    wpss_gain u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .win_valid  (win_valid),
        .win_ready  (win_ready),
        .win_data   (win_data),
        .turn_valid (turn_valid),
        .turn_ready (turn_ready),
        .turn_data  (turn_data)
    );

    wpss_speed u_speed (
        .clk         (clk),
        .rst_n       (rst_n),
        .turn_valid  (turn_valid),
        .turn_ready  (turn_ready),
        .turn_data   (turn_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .steer       (steer),
        .drive_speed (drive_speed)
    );

    // A draining output means no stage of the pipeline can hold the input back.
    a_ready_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while the output drains");

    // Only a stop beat gives zero speed, and it must also give zero steer.
    a_stop_zero_steer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && drive_speed == '0) |-> steer == '0)
        else $error("stop beat with non-zero steer");

    // The only negative speed is the reverse speed.
    a_negative_is_reverse: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && drive_speed[SPEED_BITS-1]) |-> drive_speed == SPEED_REVERSE)
        else $error("negative speed other than reverse");

endmodule

>>> tb/tb_windowed_pi_steering_speed_unit.sv
// ----------------------------------------------------------------------------
// tb_windowed_pi_steering_speed_unit
// Self-checking testbench for the windowed PI steering and speed unit. A
// behavioural copy of the error window, running sum and gains predicts the
// steer and speed of every accepted input beat. Each output beat is compared
// field by field with the oldest prediction. Stimulus runs from directed
// extremes through random command runs under random gains, with random
// idling on both channels, a long output hold-off and a final idle-free part.
// ----------------------------------------------------------------------------
module tb_windowed_pi_steering_speed_unit;

    import wpss_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic signed [ANGLE_BITS-1:0] ANGLE_MAX = {1'b0, {(ANGLE_BITS-1){1'b1}}};
    localparam logic signed [ANGLE_BITS-1:0] ANGLE_MIN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

    localparam longint STEER_MAX     = 32767;
    localparam longint STEER_MIN     = -32768;
    localparam longint GO_SPEED_BASE = 3723264;
    localparam longint GO_SPEED_STEP = 400;
    localparam longint GO_SPEED_DIV  = 450;

    localparam int DRAIN_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int PRINT_LIMIT    = 100;

    typedef struct {
        logic signed [ANGLE_BITS-1:0] steer;
        logic signed [SPEED_BITS-1:0] speed;
    } motion_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [GAIN_BITS-1:0]          cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [ANGLE_BITS-1:0]  heading;
    logic [CMD_BITS-1:0]           drive_cmd;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [ANGLE_BITS-1:0]  steer;
    logic signed [SPEED_BITS-1:0]  drive_speed;

    longint              err_ring [WINDOW];
    int                  ring_head;
    int                  ring_fill;
    longint              err_total;
    logic [CMD_BITS-1:0] last_cmd;
    longint              gain_p;
    longint              gain_i;
    longint              gain_d;

    motion_t awaited_motion [$];
    int      mismatch_count;
    bit      tx_gaps;
    bit      rx_stalls;
    int      hold_cycles;

    windowed_pi_steering_speed_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .heading     (heading),
        .drive_cmd   (drive_cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .steer       (steer),
        .drive_speed (drive_speed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("FAIL windowed_pi_steering_speed_unit");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic longint floor_quot(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den != 0) && (num < 0))
            q = q - 1;
        return q;
    endfunction

    function automatic void advance_controller(input logic signed [ANGLE_BITS-1:0] hdg,
                                               input logic [CMD_BITS-1:0] cmd);
        longint  err;
        longint  num;
        longint  den;
        longint  turn;
        longint  mag;
        longint  speed;
        motion_t m;
        err = hdg;
        if (cmd != last_cmd)
        begin
            ring_head = 0;
            ring_fill = 0;
            err_total = 0;
        end
        last_cmd = cmd;
        if (ring_fill >= WINDOW)
        begin
            err_total          = err_total - err_ring[ring_head];
            err_ring[ring_head] = err;
            ring_head          = (ring_head + 1) % WINDOW;
        end
        else
        begin
            err_ring[(ring_head + ring_fill) % WINDOW] = err;
            ring_fill++;
        end
        err_total = err_total + err;

        den  = longint'(WINDOW) * 4096;
        num  = (gain_p + gain_d) * err * WINDOW + gain_i * err_total;
        turn = floor_quot(2 * num + den, 2 * den);
        if (turn > STEER_MAX)
            turn = STEER_MAX;
        if (turn < STEER_MIN)
            turn = STEER_MIN;

        case (cmd)
            CMD_GO:
            begin
                mag = (turn < 0) ? -turn : turn;
                if (mag > longint'(TURN_CAP))
                    mag = longint'(TURN_CAP);
                speed = floor_quot(2 * (GO_SPEED_BASE - GO_SPEED_STEP * mag) + 225,
                                   GO_SPEED_DIV);
            end
            CMD_REVERSE:  speed = SPEED_REVERSE;
            CMD_CAUTIOUS: speed = SPEED_CAUTIOUS;
            default:
            begin
                turn  = 0;
                speed = 0;
            end
        endcase

        m.steer = turn[ANGLE_BITS-1:0];
        m.speed = speed[SPEED_BITS-1:0];
        awaited_motion.push_back(m);
    endfunction

    function automatic logic signed [ANGLE_BITS-1:0] pick_heading();
        case ($urandom_range(0, 9))
            0:       return ANGLE_MAX;
            1:       return ANGLE_MIN;
            2, 3:    return ANGLE_BITS'($urandom);
            4:       return ANGLE_BITS'($urandom_range(0, 512) - 256);
            default: return ANGLE_BITS'($urandom_range(0, 20480) - 10240);
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_BITS'($urandom);
            default: return GAIN_BITS'($urandom_range(0, 8192));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back beats never drop it.
    task automatic send_beat(input logic signed [ANGLE_BITS-1:0] hdg,
                             input logic [CMD_BITS-1:0] cmd);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid  = 1'b1;
        heading   = hdg;
        drive_cmd = cmd;
        do
            @(posedge clk);
        while (!in_ready);
        advance_controller(hdg, cmd);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        int waited;
        waited   = 0;
        in_valid = 1'b0;
        while (awaited_motion.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (awaited_motion.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", awaited_motion.size()));
            awaited_motion.delete();
        end
    endtask

    // Writes the unused index first, which the block must ignore.
    task automatic set_gains(input logic [GAIN_BITS-1:0] prop,
                             input logic [GAIN_BITS-1:0] integ,
                             input logic [GAIN_BITS-1:0] deriv);
        wait_for_results();
        cfg_write = 1'b1;
        cfg_index = CFG_UNUSED;
        cfg_data  = GAIN_BITS'($urandom);
        @(negedge clk);
        cfg_index = CFG_PROP;
        cfg_data  = prop;
        @(negedge clk);
        gain_p    = prop;
        cfg_index = CFG_INTEGRAL;
        cfg_data  = integ;
        @(negedge clk);
        gain_i    = integ;
        cfg_index = CFG_DERIV;
        cfg_data  = deriv;
        @(negedge clk);
        gain_d    = deriv;
        cfg_write = 1'b0;
    endtask

    task automatic test_directed_extremes();
        send_beat(ANGLE_MAX, CMD_GO);
        send_beat(ANGLE_MIN, CMD_GO);
        send_beat(16'sd0, CMD_GO);
        send_beat(16'sd1, CMD_REVERSE);
        send_beat(-16'sd1, CMD_REVERSE);
        send_beat(16'sd9216, CMD_CAUTIOUS);
        send_beat(-16'sd9216, CMD_GO);
        send_beat(16'sd4608, CMD_GO);
        send_beat(-16'sd200, CMD_STOP);
        send_beat(16'sd300, CMD_STOP);
        send_beat(16'sd300, CMD_GO);
        set_gains('1, '1, '1);
        send_beat(ANGLE_MAX, CMD_GO);
        send_beat(ANGLE_MAX, CMD_GO);
        send_beat(ANGLE_MIN, CMD_REVERSE);
        send_beat(ANGLE_MIN, CMD_REVERSE);
        send_beat(16'sd1, CMD_CAUTIOUS);
        send_beat(-16'sd1, CMD_GO);
        set_gains('0, '0, '0);
        send_beat(ANGLE_MAX, CMD_GO);
        send_beat(ANGLE_MIN, CMD_STOP);
    endtask

    // Mostly long runs of one command so the window fills and wraps, with
    // short runs and stray commands mixed in to break them.
    task automatic test_command_runs(input int beats);
        int                  left;
        int                  run;
        logic [CMD_BITS-1:0] cmd;
        left = beats;
        while (left > 0)
        begin
            cmd = CMD_BITS'($urandom_range(0, 3));
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(5, 45);
            for (int k = 0; k < run && left > 0; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_beat(pick_heading(), CMD_BITS'($urandom_range(0, 3)));
                else
                    send_beat(pick_heading(), cmd);
                left--;
            end
        end
    endtask

    task automatic test_output_hold_off();
        logic [CMD_BITS-1:0] cmd;
        cmd         = CMD_BITS'($urandom_range(0, 3));
        tx_gaps     = 1'b0;
        hold_cycles = 80;
        repeat (60) send_beat(pick_heading(), cmd);
        tx_gaps     = 1'b1;
    endtask

    task automatic test_window_across_pause();
        repeat (15) send_beat(pick_heading(), CMD_GO);
        wait_for_results();
        repeat (15) send_beat(pick_heading(), CMD_GO);
    endtask

    initial
    begin : ready_driver
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
                out_ready   = 1'b1;
            end
            else if (rx_stalls && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_ready = 1'b1;
            end
            else
                out_ready = 1'b1;
        end
    end

    initial
    begin : result_checker
        motion_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (awaited_motion.size() == 0)
                    report_mismatch("output beat with no input beat outstanding");
                else
                begin
                    want = awaited_motion.pop_front();
                    if (steer !== want.steer)
                        report_mismatch($sformatf("steer %0d, expected %0d",
                                                  steer, want.steer));
                    if (drive_speed !== want.speed)
                        report_mismatch($sformatf("drive_speed %0d, expected %0d",
                                                  drive_speed, want.speed));
                end
            end
        end
    end

    initial
    begin : test_sequence
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = CFG_PROP;
        cfg_data       = '0;
        in_valid       = 1'b0;
        heading        = '0;
        drive_cmd      = CMD_GO;
        mismatch_count = 0;
        tx_gaps        = 1'b1;
        rx_stalls      = 1'b1;
        hold_cycles    = 0;
        foreach (err_ring[k])
            err_ring[k] = 0;
        ring_head = 0;
        ring_fill = 0;
        err_total = 0;
        last_cmd  = CMD_GO;
        gain_p    = PROP_RESET;
        gain_i    = INTEGRAL_RESET;
        gain_d    = DERIV_RESET;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_extremes();
        set_gains(PROP_RESET, INTEGRAL_RESET, DERIV_RESET);
        test_command_runs(200);
        for (int phase = 0; phase < 5; phase++)
        begin
            set_gains(pick_gain(), pick_gain(), pick_gain());
            test_command_runs(200);
        end
        test_output_hold_off();
        test_window_across_pause();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        set_gains(pick_gain(), pick_gain(), pick_gain());
        test_command_runs(250);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("PASS windowed_pi_steering_speed_unit");
        else
            $display("FAIL windowed_pi_steering_speed_unit");
        $finish;
    end

endmodule
